@@ hdl/otc_pkg.sv @@
`timescale 1ns / 1ps

package otc_pkg;

  // Sample and accumulator widths
  localparam int SAMPLE_W  = 10;
  localparam int MAX_ORDER = 6;
  localparam int ORDER_W   = 3;
  localparam int SUM_W     = SAMPLE_W + 2 * MAX_ORDER;
  localparam int CNT_W     = 2 * MAX_ORDER;
  localparam int DEN_W     = SAMPLE_W + MAX_ORDER;
  localparam int DIFF_W    = SUM_W + 1;

  // Calibration divide: |avg - c30| * 550000 / |c85 - c30|
  localparam int SCALE_W   = 20;
  localparam int PROD_W    = SUM_W + SCALE_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam logic [SCALE_W-1:0] SCALE_NUM = 20'd550000;

  // Quotients at or above 2^CLAMP_BIT saturate the result either way
  localparam int CLAMP_BIT = 23;

  // Celsius to Fahrenheit, hundredths
  localparam int T_W    = 26;
  localparam int NT_W   = 29;
  localparam int M5_W   = 27;
  localparam int R5_W   = 28;
  localparam int K5     = 30;
  localparam int P5_W   = M5_W + R5_W;
  localparam int Q5_W   = P5_W - K5;
  localparam int F_W    = 26;
  localparam int M100_W = 24;
  localparam int R100_W = 25;
  localparam int K100   = 31;
  localparam int P100_W = M100_W + R100_W;
  localparam int TMAG_W = P100_W - K100;
  localparam int TEMP_W = 16;

  localparam logic signed [T_W-1:0] T_OFFSET = 26'sd300000;
  localparam logic signed [F_W-1:0] F_OFFSET = 26'sd320000;
  localparam logic [R5_W-1:0]       R5       = 28'd214748365;
  localparam logic [R100_W-1:0]     R100     = 25'd21474837;

  // Register file
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ORDER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAL30 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAL85 = 2'd2;

  typedef struct packed {
    logic [ORDER_W-1:0]  order;
    logic [SAMPLE_W-1:0] cal_30;
    logic [SAMPLE_W-1:0] cal_85;
  } otc_cfg_t;

  typedef struct packed {
    logic acc;
    logic diff;
    logic mul;
    logic div_step;
    logic t;
    logic nt;
    logic d5;
    logic f;
    logic af;
    logic d100;
    logic load;
  } otc_cmd_t;

  typedef struct packed {
    logic batch_done;
    logic cal_err;
    logic div_last;
    logic out_free;
  } otc_sts_t;

endpackage

@@ hdl/oversampled_temp_calibrator.sv @@
`timescale 1ns / 1ps
// A sample that does not close a batch is accumulated and the input stays ready.
// A sample that closes a batch is followed by these steps: the difference is formed, then the
// multiply, the 42-step restoring divide, six scaling steps and the load of the output word.
// Input is held off until the load, which waits while the output register is still full;
// equal readings skip the multiply, divide and scaling. A finished word waits in the output register.
// Reset (async, active low) clears the accumulator, the controller and the registers
// (order 0, 30 C reading 0, 85 C reading 1023).

module oversampled_temp_calibrator import otc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_W-1:0]      sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [TEMP_W-1:0] temp_hundredths_f_o,
  output logic                     cal_error_o,
  output logic                     saturated_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  otc_cfg_t cfg;
  otc_cmd_t cmd;
  otc_sts_t sts;

  otc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  otc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sample_i            (sample_i),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .temp_hundredths_f_o (temp_hundredths_f_o),
    .cal_error_o         (cal_error_o),
    .saturated_o         (saturated_o)
  );

endmodule

@@ hdl/otc_regs.sv @@
`timescale 1ns / 1ps

module otc_regs import otc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output otc_cfg_t          cfg_o
);

  logic [ORDER_W-1:0]   order_q;
  logic [SAMPLE_W-1:0]  cal30_q;
  logic [SAMPLE_W-1:0]  cal85_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      cal30_q <= '0;
      cal85_q <= '1;
    end else if (wr_en) begin
      case (idx)
        REG_ORDER: order_q <= pwdata[ORDER_W-1:0];
        REG_CAL30: cal30_q <= pwdata[SAMPLE_W-1:0];
        REG_CAL85: cal85_q <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORDER: prdata = DATA_W'(order_q);
      REG_CAL30: prdata = DATA_W'(cal30_q);
      REG_CAL85: prdata = DATA_W'(cal85_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.order  = order_q;
  assign cfg_o.cal_30 = cal30_q;
  assign cfg_o.cal_85 = cal85_q;

endmodule

@@ hdl/otc_ctrl.sv @@
`timescale 1ns / 1ps

module otc_ctrl import otc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  otc_sts_t sts_i,
  output otc_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_T    = 4'd4;
  localparam logic [3:0] S_NT   = 4'd5;
  localparam logic [3:0] S_D5   = 4'd6;
  localparam logic [3:0] S_F    = 4'd7;
  localparam logic [3:0] S_AF   = 4'd8;
  localparam logic [3:0] S_D100 = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.acc = in_valid_i;
        if (in_valid_i && sts_i.batch_done) state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        // skip the multiply, divide and scaling when the readings match
        state_d = sts_i.cal_err ? S_OUT : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_T;
      end
      S_T: begin
        cmd_o.t = 1'b1;
        state_d = S_NT;
      end
      S_NT: begin
        cmd_o.nt = 1'b1;
        state_d  = S_D5;
      end
      S_D5: begin
        cmd_o.d5 = 1'b1;
        state_d  = S_F;
      end
      S_F: begin
        cmd_o.f = 1'b1;
        state_d = S_AF;
      end
      S_AF: begin
        cmd_o.af = 1'b1;
        state_d  = S_D100;
      end
      S_D100: begin
        cmd_o.d100 = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/otc_dp.sv @@
`timescale 1ns / 1ps

module otc_dp import otc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  otc_cfg_t                 cfg_i,
  input  otc_cmd_t                 cmd_i,
  output otc_sts_t                 sts_o,
  input  logic [SAMPLE_W-1:0]      sample_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [TEMP_W-1:0] temp_hundredths_f_o,
  output logic                     cal_error_o,
  output logic                     saturated_o
);

  // accumulator
  logic [SUM_W-1:0]       sum_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SUM_W-1:0]       sum_nx;
  logic [CNT_W:0]         cnt_nx;
  logic [CNT_W:0]         needed;
  logic [ORDER_W-1:0]     n;
  logic                   batch_done;

  // calibration
  logic [DEN_W-1:0]       c30;
  logic [SAMPLE_W:0]      cal_diff;
  logic [SAMPLE_W:0]      cal_diff_neg;
  logic [SAMPLE_W-1:0]    cal_mag;
  logic [DEN_W-1:0]       den_mag;
  logic                   den_neg;
  logic                   cal_err;

  // divide
  logic [SUM_W-1:0]       avg_q;
  logic [DIFF_W-1:0]      diff;
  logic [DIFF_W-1:0]      diff_neg;
  logic [SUM_W-1:0]       diff_mag_q;
  logic                   diff_neg_q;
  logic                   q_neg_q;
  logic [PROD_W-1:0]      quo_q;
  logic [DEN_W-1:0]       rem_q;
  logic [DEN_W:0]         rem_sh;
  logic                   q_bit;
  logic [DIV_CNT_W-1:0]   div_cnt_q;

  // scaling
  logic [CLAMP_BIT:0]       qc;
  logic signed [T_W-1:0]    q_s;
  logic signed [T_W-1:0]    t_q;
  logic signed [NT_W-1:0]   t_ext;
  logic signed [NT_W-1:0]   nt;
  logic [NT_W-1:0]          nt_neg;
  logic [M5_W-1:0]          m5_q;
  logic                     s5_q;
  logic [P5_W-1:0]          p5_q;
  logic [Q5_W-1:0]          q5;
  logic signed [F_W-1:0]    q5_s;
  logic signed [F_W-1:0]    f_q;
  logic [F_W-1:0]           f_neg;
  logic [M100_W-1:0]        m100_q;
  logic                     s100_q;
  logic [P100_W-1:0]        p100_q;
  logic [TMAG_W-1:0]        tmag;
  logic signed [TMAG_W:0]   temp_s;

  // output register
  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     err_q;
  logic                     sat_q;
  logic signed [TEMP_W-1:0] temp_d;
  logic                     sat_d;

  assign n          = (cfg_i.order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : cfg_i.order;
  assign needed     = (CNT_W + 1)'(1) << {n, 1'b0};
  assign sum_nx     = sum_q + SUM_W'(sample_i);
  assign cnt_nx     = {1'b0, cnt_q} + (CNT_W + 1)'(1);
  assign batch_done = (cnt_nx >= needed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.acc) begin
      if (batch_done) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_nx;
        cnt_q <= cnt_nx[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && batch_done) avg_q <= sum_nx >> n;
  end

  assign c30          = DEN_W'(cfg_i.cal_30) << n;
  assign cal_diff     = {1'b0, cfg_i.cal_85} - {1'b0, cfg_i.cal_30};
  assign cal_diff_neg = -cal_diff;
  assign den_neg      = cal_diff[SAMPLE_W];
  assign cal_mag      = den_neg ? cal_diff_neg[SAMPLE_W-1:0] : cal_diff[SAMPLE_W-1:0];
  assign den_mag      = DEN_W'(cal_mag) << n;
  assign cal_err      = (cfg_i.cal_30 == cfg_i.cal_85);

  assign diff     = {1'b0, avg_q} - DIFF_W'(c30);
  assign diff_neg = -diff;

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_mag});

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      diff_neg_q <= diff[DIFF_W-1];
      diff_mag_q <= diff[DIFF_W-1] ? diff_neg[SUM_W-1:0] : diff[SUM_W-1:0];
    end
    if (cmd_i.mul) begin
      quo_q   <= diff_mag_q * SCALE_NUM;
      q_neg_q <= diff_neg_q ^ den_neg;
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[PROD_W-2:0], q_bit};
      rem_q <= q_bit ? DEN_W'(rem_sh - {1'b0, den_mag}) : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.mul) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  // clamp large quotients: they saturate in the same direction
  assign qc     = (|quo_q[PROD_W-1:CLAMP_BIT]) ? {1'b1, {CLAMP_BIT{1'b0}}}
                                               : {1'b0, quo_q[CLAMP_BIT-1:0]};
  assign q_s    = q_neg_q ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
  assign t_ext  = NT_W'(t_q);
  assign nt     = (t_ext <<< 3) + t_ext;
  assign nt_neg = -nt;
  assign q5     = p5_q[P5_W-1:K5];
  assign q5_s   = $signed({1'b0, q5});
  assign f_neg  = -f_q;
  assign tmag   = p100_q[P100_W-1:K100];
  assign temp_s = s100_q ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});

  always_ff @(posedge clk_i) begin
    if (cmd_i.t) t_q <= q_s + T_OFFSET;
    if (cmd_i.nt) begin
      s5_q <= nt[NT_W-1];
      m5_q <= nt[NT_W-1] ? nt_neg[M5_W-1:0] : nt[M5_W-1:0];
    end
    if (cmd_i.d5) p5_q <= m5_q * R5;
    if (cmd_i.f) f_q <= (s5_q ? -q5_s : q5_s) + F_OFFSET;
    if (cmd_i.af) begin
      s100_q <= f_q[F_W-1];
      m100_q <= f_q[F_W-1] ? f_neg[M100_W-1:0] : f_q[M100_W-1:0];
    end
    if (cmd_i.d100) p100_q <= m100_q * R100;
  end

  always_comb begin
    sat_d  = 1'b0;
    temp_d = temp_s[TEMP_W-1:0];
    if (temp_s > (TMAG_W + 1)'(32767)) begin
      sat_d  = 1'b1;
      temp_d = {1'b0, {(TEMP_W - 1){1'b1}}};
    end else if (temp_s < -(TMAG_W + 1)'(32768)) begin
      sat_d  = 1'b1;
      temp_d = {1'b1, {(TEMP_W - 1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q  <= cal_err;
      sat_q  <= cal_err ? 1'b0 : sat_d;
      temp_q <= cal_err ? '0 : temp_d;
    end
  end

  assign sts_o.batch_done = batch_done;
  assign sts_o.cal_err    = cal_err;
  assign sts_o.div_last   = (div_cnt_q == DIV_CNT_W'(PROD_W - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign temp_hundredths_f_o = temp_q;
  assign cal_error_o         = err_q;
  assign saturated_o         = sat_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unaccepted word");

  a_batch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc && batch_done) |=> (sum_q == '0 && cnt_q == '0))
    else $error("accumulator not cleared after a closed batch");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(err_q && sat_q))
    else $error("cal_error and saturated both set");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (temp_q == '0))
    else $error("nonzero temperature with calibration error");

endmodule
